[rtl/assert_macros.svh]
// Assertion macros used by the ranger datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fser_pkg.sv]
// Shared constants and control types of the four sonar echo ranger.
package fser_pkg;

  localparam int COUNT_BITS_DEF = 18;
  localparam int PERIOD_W       = 19;
  localparam int TRIG_W         = 8;
  localparam int DIV_W          = 10;
  localparam int DIST_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 19;
  localparam int NUM_CH         = 3;
  localparam int NUM_DIST       = 4;
  localparam int LEVEL_W        = 4;

  localparam logic [DIST_W-1:0]     DIST_MAX      = 16'hFFFF;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = 19'd262144;
  localparam logic [TRIG_W-1:0]     TRIG_RESET    = 8'd16;
  localparam logic [DIV_W-1:0]      DIV_RESET     = 10'd58;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV    = 2'd2;

  localparam logic [1:0] CH_FRONT = 2'd0;
  localparam logic [1:0] CH_SL    = 2'd1;
  localparam logic [1:0] CH_SR    = 2'd2;

  localparam logic [1:0] SLOT_FL = 2'd0;
  localparam logic [1:0] SLOT_FR = 2'd1;
  localparam logic [1:0] SLOT_SL = 2'd2;
  localparam logic [1:0] SLOT_SR = 2'd3;

  typedef struct packed {
    logic step;
    logic div_start;
    logic div_run;
    logic div_store;
    logic load_out;
  } fser_cmd_t;

  typedef struct packed {
    logic pend_any;
    logic div_last;
    logic out_free;
  } fser_stat_t;

endpackage

[rtl/fser_ctrl.sv]
// Sequencer of the ranger: tick update, divisions, output load.
module fser_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fser_pkg::fser_stat_t stat,
  output fser_pkg::fser_cmd_t  cmd
);
  import fser_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.pend_any) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.div_store = 1'b1;
        state_next    = S_SCAN;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/fser_datapath.sv]
// Datapath of the ranger: registers, echo channels, divider, output word.
`include "assert_macros.svh"

module fser_datapath #(
  parameter int COUNT_BITS = fser_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fser_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fser_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                echo_front_left,
  input  logic                                echo_front_right,
  input  logic                                echo_side_left,
  input  logic                                echo_side_right,
  input  fser_pkg::fser_cmd_t                 cmd,
  output fser_pkg::fser_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                trig_front_left,
  output logic                                trig_front_right,
  output logic                                trig_sides,
  output logic                                front_is_left,
  output logic [fser_pkg::DIST_W-1:0]         dist_front_left,
  output logic [fser_pkg::DIST_W-1:0]         dist_front_right,
  output logic [fser_pkg::DIST_W-1:0]         dist_side_left,
  output logic [fser_pkg::DIST_W-1:0]         dist_side_right
);
  import fser_pkg::*;

  localparam int CNT_W = $clog2(COUNT_BITS + 1);
  localparam int LIM_W = (COUNT_BITS + 1 > PERIOD_W) ? COUNT_BITS + 1 : PERIOD_W;
  localparam logic [COUNT_BITS-1:0] WIDTH_MAX = '1;
  localparam logic [COUNT_BITS-1:0] DMAX = COUNT_BITS'(DIST_MAX);
  localparam logic [LIM_W-1:0] LIM_TOP = LIM_W'(1) << COUNT_BITS;

  logic [PERIOD_W-1:0]   period_ticks;
  logic [TRIG_W-1:0]     trigger_ticks;
  logic [DIV_W-1:0]      ticks_per_cm;

  logic [COUNT_BITS-1:0] period_count;
  logic                  front_sel;
  logic [LEVEL_W-1:0]    prev_lv;
  logic [COUNT_BITS-1:0] echo_width [NUM_CH];
  logic [NUM_CH-1:0]     echo_open;
  logic [NUM_CH-1:0]     pend;
  logic [DIST_W-1:0]     dist_reg [NUM_DIST];

  logic [COUNT_BITS-1:0] snap [NUM_CH];
  logic [1:0]            front_slot;
  logic                  trig_s;
  logic                  sel_s;
  logic [COUNT_BITS-1:0] div_q;
  logic [DIV_W-1:0]      div_r;
  logic [CNT_W-1:0]      div_cnt;
  logic [1:0]            div_ch;

  logic [LEVEL_W-1:0]    lv;
  logic                  trig;
  logic [NUM_CH-1:0]     cur;
  logic [NUM_CH-1:0]     prv;
  logic [NUM_CH-1:0]     fall;
  logic [COUNT_BITS-1:0] width_inc [NUM_CH];
  logic [COUNT_BITS-1:0] width_next [NUM_CH];
  logic [NUM_CH-1:0]     open_next;
  logic [LIM_W-1:0]      limit;
  logic [LIM_W-1:0]      count_inc;
  logic                  wrap;
  logic [1:0]            pick;
  logic [DIV_W:0]        shifted;
  logic                  ge;
  logic [DIV_W-1:0]      r_next;
  logic [1:0]            store_slot;
  logic [DIST_W-1:0]     dist_val;
  logic                  out_take;

  assign lv = {echo_side_right, echo_side_left, echo_front_right, echo_front_left};
  assign trig = period_count < COUNT_BITS'(trigger_ticks);

  assign cur = {lv[3], lv[2], front_sel ? lv[0] : lv[1]};
  assign prv = {prev_lv[3], prev_lv[2], front_sel ? prev_lv[0] : prev_lv[1]};

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      width_inc[i] = (echo_open[i] && echo_width[i] != WIDTH_MAX) ?
                     echo_width[i] + COUNT_BITS'(1) : echo_width[i];
      fall[i] = !cur[i] && prv[i] && echo_open[i];
      if (cur[i] && !prv[i]) begin
        width_next[i] = '0;
        open_next[i]  = 1'b1;
      end else if (fall[i]) begin
        width_next[i] = '0;
        open_next[i]  = 1'b0;
      end else begin
        width_next[i] = width_inc[i];
        open_next[i]  = echo_open[i];
      end
    end
    // drop an open front echo at period wrap
    if (wrap) begin
      width_next[0] = '0;
      open_next[0]  = 1'b0;
    end
  end

  assign limit = (LIM_W'(period_ticks) > LIM_TOP) ? LIM_TOP : LIM_W'(period_ticks);
  assign count_inc = LIM_W'(period_count) + LIM_W'(1);
  assign wrap = count_inc >= limit;

  always_comb begin
    if (pend[0]) begin
      pick = CH_FRONT;
    end else if (pend[1]) begin
      pick = CH_SL;
    end else begin
      pick = CH_SR;
    end
  end

  assign shifted = {div_r, div_q[COUNT_BITS-1]};
  assign ge = shifted >= {1'b0, ticks_per_cm};
  assign r_next = ge ? DIV_W'(shifted - {1'b0, ticks_per_cm}) : shifted[DIV_W-1:0];

  always_comb begin
    unique case (div_ch)
      CH_FRONT: store_slot = front_slot;
      CH_SL:    store_slot = SLOT_SL;
      CH_SR:    store_slot = SLOT_SR;
      default:  store_slot = SLOT_SR;
    endcase
  end

  assign dist_val = (div_q > DMAX) ? DIST_MAX : div_q[DIST_W-1:0];

  assign out_take = out_valid && !out_stall;

  assign stat.pend_any = |pend;
  assign stat.div_last = (div_cnt == CNT_W'(COUNT_BITS - 1));
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks  <= PERIOD_RESET;
      trigger_ticks <= TRIG_RESET;
      ticks_per_cm  <= DIV_RESET;
      period_count  <= '0;
      front_sel     <= 1'b1;
      prev_lv       <= '1;
      echo_open     <= '0;
      pend          <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        echo_width[i] <= '0;
      end
      for (int i = 0; i < NUM_DIST; i++) begin
        dist_reg[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PERIOD: period_ticks  <= cfg_data[PERIOD_W-1:0];
          REG_TRIG:   trigger_ticks <= cfg_data[TRIG_W-1:0];
          REG_DIV:    ticks_per_cm  <= cfg_data[DIV_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.step) begin
        prev_lv <= lv;
        pend    <= fall;
        for (int i = 0; i < NUM_CH; i++) begin
          echo_width[i] <= width_next[i];
          echo_open[i]  <= open_next[i];
        end
        if (wrap) begin
          period_count <= '0;
          front_sel    <= !front_sel;
        end else begin
          period_count <= COUNT_BITS'(count_inc);
        end
      end
      if (cmd.div_store) begin
        dist_reg[store_slot] <= dist_val;
        pend[div_ch]         <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      trig_s     <= trig;
      sel_s      <= front_sel;
      front_slot <= front_sel ? SLOT_FL : SLOT_FR;
      for (int i = 0; i < NUM_CH; i++) begin
        if (fall[i]) begin
          snap[i] <= width_inc[i];
        end
      end
    end
    if (cmd.div_start) begin
      div_q   <= snap[pick];
      div_r   <= '0;
      div_cnt <= '0;
      div_ch  <= pick;
    end else if (cmd.div_run) begin
      div_q   <= {div_q[COUNT_BITS-2:0], ge};
      div_r   <= r_next;
      div_cnt <= div_cnt + CNT_W'(1);
    end
    if (cmd.load_out) begin
      trig_front_left  <= trig_s && sel_s;
      trig_front_right <= trig_s && !sel_s;
      trig_sides       <= trig_s;
      front_is_left    <= sel_s;
      dist_front_left  <= dist_reg[SLOT_FL];
      dist_front_right <= dist_reg[SLOT_FR];
      dist_side_left   <= dist_reg[SLOT_SL];
      dist_side_right  <= dist_reg[SLOT_SR];
    end
  end

  `ASSERT_CLK(a_step_drained, cmd.step |-> (pend == '0), "item accepted with divisions pending")
  `ASSERT_CLK(a_store_pending, cmd.div_store |-> pend[div_ch], "distance stored for idle channel")
  `ASSERT_CLK(a_load_free, cmd.load_out |-> (!out_valid || !out_stall), "output word overwritten")

endmodule

[rtl/four_sonar_echo_ranger.sv]
// Top level of the four sonar echo ranger.
//
//  port group   dir  handshake             contents
//  in_*         in   in_valid / in_stall   four sampled echo levels, one word per tick
//  out_*        out  out_valid / out_stall triggers, front select, four distances
//  cfg_*        in   cfg_we                period_ticks, trigger_ticks, ticks_per_cm
//
// A tick with no falling echo edge goes from idle through scan to the load state,
// where its output word is loaded; in_stall stays high until the state is idle again.
// Each falling edge adds a division on the shared restoring divider (start in scan,
// divide, then store), and the channels with edges are divided one after another.
// Reset is synchronous; the divider, snapshot and output data registers are not reset.
// A stalled output word holds; the next tick is taken meanwhile and waits to load.
module four_sonar_echo_ranger #(
  parameter int COUNT_BITS = fser_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fser_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fser_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            echo_front_left,
  input  logic                            echo_front_right,
  input  logic                            echo_side_left,
  input  logic                            echo_side_right,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            trig_front_left,
  output logic                            trig_front_right,
  output logic                            trig_sides,
  output logic                            front_is_left,
  output logic [fser_pkg::DIST_W-1:0]     dist_front_left,
  output logic [fser_pkg::DIST_W-1:0]     dist_front_right,
  output logic [fser_pkg::DIST_W-1:0]     dist_side_left,
  output logic [fser_pkg::DIST_W-1:0]     dist_side_right
);
  import fser_pkg::*;

  fser_cmd_t  cmd;
  fser_stat_t stat;

  fser_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fser_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .echo_front_left  (echo_front_left),
    .echo_front_right (echo_front_right),
    .echo_side_left   (echo_side_left),
    .echo_side_right  (echo_side_right),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .trig_front_left  (trig_front_left),
    .trig_front_right (trig_front_right),
    .trig_sides       (trig_sides),
    .front_is_left    (front_is_left),
    .dist_front_left  (dist_front_left),
    .dist_front_right (dist_front_right),
    .dist_side_left   (dist_side_left),
    .dist_side_right  (dist_side_right)
  );

endmodule
